// ===== hdl/pid_motor_speed_duty_update_defines.svh =====
// Assertion macros shared by the speed controller RTL.
// Depends on nothing; included by the top level, which writes its checks with them.
`ifndef PID_MOTOR_SPEED_DUTY_UPDATE_DEFINES_SVH
`define PID_MOTOR_SPEED_DUTY_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PMSD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PMSD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pmsd_pkg.sv =====
// Constants, reset values and register codes of the PID speed controller.
// Depends on nothing; used by the channel interfaces and the top level.
package pmsd_pkg;

  // Parameter defaults.
  localparam int COUNT_BITS_DEF     = 10;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  // Fixed field widths.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int GAIN_W    = 16;
  localparam int DUTY_W    = 8;
  localparam int CORR_W    = 6;
  localparam int MEAS_W    = 19;

  // Speed conversion: rpm = (count * 468750) >> 10.
  localparam int SPEED_MUL   = 468750;
  localparam int SPEED_MUL_W = 19;
  localparam int SPEED_SHIFT = 10;

  // Term scalings: proportional divides by 625, integral by 3 * 5^11,
  // derivative multiplies by 375; all terms are Q.16.
  localparam int T1_DIV     = 625;
  localparam int T1_DIV_W   = 10;
  localparam int T3_DIV     = 146484375;
  localparam int T3_DIV_W   = 28;
  localparam int T2_MUL     = 375;
  localparam int T2_MUL_W   = 9;
  localparam int TERM_SHIFT = 16;

  // Correction fold and duty saturation.
  localparam int FOLD_LIMIT = 20;
  localparam int FOLD_VALUE = 8;
  localparam int DUTY_MAX   = 254;
  localparam int DUTY_MIN   = 1;
  localparam int DUTY_RESET = 128;

  // Register reset values.
  localparam int TARGET_RESET = 3600;
  localparam int PROP_RESET   = 3072;
  localparam int INTEG_RESET  = 0;
  localparam int DERIV_RESET  = 0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SPEED = 2'd0,
    CFG_PROP_GAIN    = 2'd1,
    CFG_INTEG_GAIN   = 2'd2,
    CFG_DERIV_GAIN   = 2'd3
  } cfg_idx_t;

endpackage

// ===== hdl/pmsd_if.sv =====
// Valid/ready channel interfaces for the pulse count input and the duty result.
// Depends on pmsd_pkg for field widths and parameter defaults.
interface pmsd_in_if #(
  parameter int COUNT_BITS = pmsd_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] pulse_count;

  modport source (output valid, output pulse_count, input ready);
  modport sink (input valid, input pulse_count, output ready);
endinterface

interface pmsd_out_if;
  logic                                valid;
  logic                                ready;
  logic [pmsd_pkg::DUTY_W-1:0]         duty;
  logic signed [pmsd_pkg::CORR_W-1:0]  correction;
  logic [pmsd_pkg::MEAS_W-1:0]         measured_speed;

  modport source (output valid, output duty, output correction, output measured_speed,
                  input ready);
  modport sink (input valid, input duty, input correction, input measured_speed,
                output ready);
endinterface

// ===== hdl/pid_motor_speed_duty_update.sv =====
// Top level of the PID motor speed controller: one duty update per sampling tick.
// Depends on pmsd_pkg, the pmsd_in_if / pmsd_out_if channels and the defines header.
//
// Usage: each item on in_chan carries the encoder pulse count of one sampling
// period. The block converts it to rpm, forms the error against target_speed,
// runs a PID correction and returns one item on out_chan with the new duty
// (1..254), the folded integer correction and the measured speed.
// The cfg port writes target_speed and the three Q8.8 gains (index 0..3);
// write it only while no item is in flight.
// The three gain products run as shift-add multipliers, one gain bit per cycle,
// and the two constant divisions as restoring dividers, one
// quotient bit per cycle (DIV_W = COUNT_BITS + 47 - GAIN_FRAC_BITS steps).
// A new item is accepted only in the idle state, after the previous one has
// left the final step, so items never overlap. The result sits in an output
// register, so the next item is accepted while it waits; if the receiver
// still stalls when the following result is ready, that result holds in
// the final step until the register frees.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// previous error, sets the duty to 128 and empties the output register.
`include "pid_motor_speed_duty_update_defines.svh"

module pid_motor_speed_duty_update #(
  parameter int COUNT_BITS     = pmsd_pkg::COUNT_BITS_DEF,
  parameter int GAIN_FRAC_BITS = pmsd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmsd_pkg::CFG_W-1:0]       cfg_data,
  pmsd_in_if.sink                          in_chan,
  pmsd_out_if.source                       out_chan
);

  // Derived widths.
  localparam int GAIN_W   = pmsd_pkg::GAIN_W;
  localparam int DUTY_W   = pmsd_pkg::DUTY_W;
  localparam int CORR_W   = pmsd_pkg::CORR_W;
  localparam int MEAS_W   = pmsd_pkg::MEAS_W;
  localparam int SHIFT_Q  = pmsd_pkg::TERM_SHIFT;
  localparam int PROD_W   = COUNT_BITS + pmsd_pkg::SPEED_MUL_W;
  localparam int SPD_W    = COUNT_BITS + 9;
  localparam int ERR_W    = COUNT_BITS + 10;
  localparam int DS_W     = ERR_W + 1;
  localparam int MUL_W    = GAIN_W + DS_W;
  localparam int WIDE_W   = MUL_W + SHIFT_Q;
  localparam int DIV_W    = MUL_W + 20 - GAIN_FRAC_BITS;
  localparam int T2_W     = MUL_W + pmsd_pkg::T2_MUL_W;
  localparam int MAG_W    = (DIV_W > T2_W) ? DIV_W : T2_W;
  localparam int SUM_W    = MAG_W + 3;
  localparam int HI_W     = SUM_W - SHIFT_Q;
  localparam int CNT_W    = $clog2(DIV_W);
  localparam int R1_W     = pmsd_pkg::T1_DIV_W;
  localparam int R3_W     = pmsd_pkg::T3_DIV_W;
  localparam int DCALC_W  = DUTY_W + 2;
  localparam int FOLD_W   = CORR_W - 1;
  localparam int T1_SHIFT = GAIN_FRAC_BITS + 4;
  localparam int T2_SHIFT = GAIN_FRAC_BITS - 3;
  localparam int T3_SHIFT = GAIN_FRAC_BITS - 4;

  // Multiplier lanes.
  localparam int LANES  = 3;
  localparam int LANE_P = 0;
  localparam int LANE_D = 1;
  localparam int LANE_I = 2;

  // Sized constants.
  localparam logic [R1_W:0]   DIV1_K = (R1_W + 1)'(pmsd_pkg::T1_DIV);
  localparam logic [R3_W:0]   DIV3_K = (R3_W + 1)'(pmsd_pkg::T3_DIV);
  localparam logic [HI_W-1:0] FOLD_LIM_K = HI_W'(pmsd_pkg::FOLD_LIMIT);
  localparam logic [FOLD_W-1:0] FOLD_VAL_K = FOLD_W'(pmsd_pkg::FOLD_VALUE);
  localparam logic signed [DCALC_W-1:0] DUTY_HI = DCALC_W'(pmsd_pkg::DUTY_MAX);
  localparam logic signed [DCALC_W-1:0] DUTY_LO = DCALC_W'(pmsd_pkg::DUTY_MIN);
  localparam logic signed [CORR_W-1:0] CORR_HI = CORR_W'(pmsd_pkg::FOLD_LIMIT - 1);
  localparam logic signed [CORR_W-1:0] CORR_LO = CORR_W'(1 - pmsd_pkg::FOLD_LIMIT);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_ERR   = 10'b0000000010,
    ST_LOAD  = 10'b0000000100,
    ST_MUL   = 10'b0000001000,
    ST_DLOAD = 10'b0000010000,
    ST_DIV   = 10'b0000100000,
    ST_SUM1  = 10'b0001000000,
    ST_SUM2  = 10'b0010000000,
    ST_CORR  = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } state_t;

  // Control and configuration registers.
  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          step_r, step_nxt;
  logic [GAIN_W-1:0]         target_r, target_nxt;
  logic [GAIN_W-1:0]         prop_r, prop_nxt;
  logic [GAIN_W-1:0]         integ_r, integ_nxt;
  logic [GAIN_W-1:0]         deriv_r, deriv_nxt;
  logic signed [ERR_W-1:0]   prev_error_r, prev_error_nxt;
  logic [DUTY_W-1:0]         duty_reg_r, duty_reg_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [SPD_W-1:0]          speed_r, speed_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic [MUL_W-1:0]          mcand_r [LANES];
  logic [MUL_W-1:0]          mcand_nxt [LANES];
  logic [GAIN_W-1:0]         mplier_r [LANES];
  logic [GAIN_W-1:0]         mplier_nxt [LANES];
  logic [MUL_W-1:0]          acc_r [LANES];
  logic [MUL_W-1:0]          acc_nxt [LANES];
  logic [LANES-1:0]          sg_r, sg_nxt;
  logic [DIV_W-1:0]          dv1_r, dv1_nxt;
  logic [DIV_W-1:0]          dv3_r, dv3_nxt;
  logic [R1_W-1:0]           rem1_r, rem1_nxt;
  logic [R3_W-1:0]           rem3_r, rem3_nxt;
  logic [T2_W-1:0]           t2mag_r, t2mag_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [CORR_W-1:0]  corr_r, corr_nxt;
  logic [DUTY_W-1:0]         out_duty_r, out_duty_nxt;
  logic signed [CORR_W-1:0]  out_corr_r, out_corr_nxt;
  logic [MEAS_W-1:0]         out_meas_r, out_meas_nxt;

  // Combinational helpers.
  logic                      in_fire;
  logic                      out_free;
  logic [PROD_W-1:0]         speed_prod;
  logic signed [DS_W-1:0]    diff_v;
  logic signed [DS_W-1:0]    sum_e;
  logic [ERR_W-1:0]          err_mag;
  logic [DS_W-1:0]           diff_mag;
  logic [DS_W-1:0]           sum_e_mag;
  logic [GAIN_W-1:0]         prop_mag;
  logic [GAIN_W-1:0]         integ_mag;
  logic [GAIN_W-1:0]         deriv_mag;
  logic [R1_W:0]             trial1;
  logic [R3_W:0]             trial3;
  logic                      ge1;
  logic                      ge3;
  logic signed [SUM_W-1:0]   t1_s;
  logic signed [SUM_W-1:0]   t2_s;
  logic signed [SUM_W-1:0]   t3_s;
  logic [SUM_W-1:0]          sum_abs;
  logic [HI_W-1:0]           corr_hi;
  logic [FOLD_W-1:0]         corr_fold;
  logic signed [DCALC_W-1:0] duty_calc;
  logic [DUTY_W-1:0]         duty_sat;

  assign in_fire  = in_chan.valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_chan.ready;

  // Speed conversion: constant multiply, then drop the low bits.
  assign speed_prod = PROD_W'(in_chan.pulse_count[COUNT_BITS-1:0]) *
                      PROD_W'(pmsd_pkg::SPEED_MUL);

  // Error difference and sum with their magnitudes for the multiplier lanes.
  assign diff_v    = DS_W'(err_r) - DS_W'(prev_error_r);
  assign sum_e     = DS_W'(err_r) + DS_W'(prev_error_r);
  assign err_mag   = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
  assign diff_mag  = diff_v[DS_W-1] ? DS_W'(-diff_v) : DS_W'(diff_v);
  assign sum_e_mag = sum_e[DS_W-1] ? DS_W'(-sum_e) : DS_W'(sum_e);
  assign prop_mag  = prop_r[GAIN_W-1] ? GAIN_W'(-prop_r) : prop_r;
  assign integ_mag = integ_r[GAIN_W-1] ? GAIN_W'(-integ_r) : integ_r;
  assign deriv_mag = deriv_r[GAIN_W-1] ? GAIN_W'(-deriv_r) : deriv_r;

  // Restoring divider steps: one quotient bit per cycle in each lane.
  assign trial1 = {rem1_r, dv1_r[DIV_W-1]};
  assign trial3 = {rem3_r, dv3_r[DIV_W-1]};
  assign ge1    = (trial1 >= DIV1_K);
  assign ge3    = (trial3 >= DIV3_K);

  // Signed terms rebuilt from magnitudes and product signs.
  assign t1_s = sg_r[LANE_P] ? -$signed(SUM_W'(dv1_r)) : $signed(SUM_W'(dv1_r));
  assign t2_s = sg_r[LANE_D] ? -$signed(SUM_W'(t2mag_r)) : $signed(SUM_W'(t2mag_r));
  assign t3_s = sg_r[LANE_I] ? -$signed(SUM_W'(dv3_r)) : $signed(SUM_W'(dv3_r));

  // Integer correction, truncated toward zero, then the fold rule.
  assign sum_abs   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign corr_hi   = sum_abs[SUM_W-1:SHIFT_Q];
  assign corr_fold = (corr_hi >= FOLD_LIM_K) ? FOLD_VAL_K : corr_hi[FOLD_W-1:0];

  // Duty update with saturation to the legal byte range.
  assign duty_calc = $signed({2'b00, duty_reg_r}) - DCALC_W'(corr_r);
  always_comb begin
    if (duty_calc > DUTY_HI) begin
      duty_sat = DUTY_W'(DUTY_HI);
    end else if (duty_calc < DUTY_LO) begin
      duty_sat = DUTY_W'(DUTY_LO);
    end else begin
      duty_sat = duty_calc[DUTY_W-1:0];
    end
  end

  // Configuration writes.
  always_comb begin
    target_nxt = target_r;
    prop_nxt   = prop_r;
    integ_nxt  = integ_r;
    deriv_nxt  = deriv_r;
    if (cfg_we) begin
      case (pmsd_pkg::cfg_idx_t'(cfg_index))
        pmsd_pkg::CFG_TARGET_SPEED: target_nxt = cfg_data;
        pmsd_pkg::CFG_PROP_GAIN:    prop_nxt   = cfg_data;
        pmsd_pkg::CFG_INTEG_GAIN:   integ_nxt  = cfg_data;
        pmsd_pkg::CFG_DERIV_GAIN:   deriv_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    prev_error_nxt = prev_error_r;
    duty_reg_nxt   = duty_reg_r;
    out_valid_nxt  = out_valid_r;
    speed_nxt      = speed_r;
    err_nxt        = err_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    acc_nxt        = acc_r;
    sg_nxt         = sg_r;
    dv1_nxt        = dv1_r;
    dv3_nxt        = dv3_r;
    rem1_nxt       = rem1_r;
    rem3_nxt       = rem3_r;
    t2mag_nxt      = t2mag_r;
    sum_nxt        = sum_r;
    corr_nxt       = corr_r;
    out_duty_nxt   = out_duty_r;
    out_corr_nxt   = out_corr_r;
    out_meas_nxt   = out_meas_r;

    // The receiver takes the held result.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          speed_nxt = SPD_W'(speed_prod >> pmsd_pkg::SPEED_SHIFT);
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        err_nxt   = $signed(ERR_W'(target_r)) - $signed(ERR_W'(speed_r));
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        mcand_nxt[LANE_P]  = MUL_W'(err_mag);
        mcand_nxt[LANE_D]  = MUL_W'(diff_mag);
        mcand_nxt[LANE_I]  = MUL_W'(sum_e_mag);
        mplier_nxt[LANE_P] = prop_mag;
        mplier_nxt[LANE_D] = deriv_mag;
        mplier_nxt[LANE_I] = integ_mag;
        for (int i = 0; i < LANES; i++) begin
          acc_nxt[i] = '0;
        end
        sg_nxt[LANE_P] = prop_r[GAIN_W-1] ^ err_r[ERR_W-1];
        sg_nxt[LANE_D] = deriv_r[GAIN_W-1] ^ diff_v[DS_W-1];
        sg_nxt[LANE_I] = integ_r[GAIN_W-1] ^ sum_e[DS_W-1];
        step_nxt  = CNT_W'(GAIN_W - 1);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // Shift-add: one gain bit per cycle in each lane.
        for (int i = 0; i < LANES; i++) begin
          if (mplier_r[i][0]) begin
            acc_nxt[i] = acc_r[i] + mcand_r[i];
          end
          mcand_nxt[i]  = {mcand_r[i][MUL_W-2:0], 1'b0};
          mplier_nxt[i] = {1'b0, mplier_r[i][GAIN_W-1:1]};
        end
        step_nxt = step_r - CNT_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_DLOAD;
        end
      end
      ST_DLOAD: begin
        // Scale to Q.16 and strip the power-of-two part of each divisor.
        dv1_nxt   = DIV_W'({acc_r[LANE_P], {SHIFT_Q{1'b0}}} >> T1_SHIFT);
        dv3_nxt   = DIV_W'({acc_r[LANE_I], {SHIFT_Q{1'b0}}} >> T3_SHIFT);
        t2mag_nxt = T2_W'((T2_W'(acc_r[LANE_D]) * T2_W'(pmsd_pkg::T2_MUL)) >> T2_SHIFT);
        rem1_nxt  = '0;
        rem3_nxt  = '0;
        step_nxt  = CNT_W'(DIV_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem1_nxt = ge1 ? R1_W'(trial1 - DIV1_K) : trial1[R1_W-1:0];
        rem3_nxt = ge3 ? R3_W'(trial3 - DIV3_K) : trial3[R3_W-1:0];
        dv1_nxt  = {dv1_r[DIV_W-2:0], ge1};
        dv3_nxt  = {dv3_r[DIV_W-2:0], ge3};
        step_nxt = step_r - CNT_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_SUM1;
        end
      end
      ST_SUM1: begin
        sum_nxt   = t1_s + t2_s;
        state_nxt = ST_SUM2;
      end
      ST_SUM2: begin
        sum_nxt   = sum_r + t3_s;
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        corr_nxt  = sum_r[SUM_W-1] ? -$signed({1'b0, corr_fold}) : $signed({1'b0, corr_fold});
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Commit state and hand the result over once the output register is free.
        if (out_free) begin
          duty_reg_nxt   = duty_sat;
          prev_error_nxt = err_r;
          out_valid_nxt  = 1'b1;
          out_duty_nxt   = duty_sat;
          out_corr_nxt   = corr_r;
          out_meas_nxt   = MEAS_W'(speed_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      target_r     <= GAIN_W'(pmsd_pkg::TARGET_RESET);
      prop_r       <= GAIN_W'(pmsd_pkg::PROP_RESET);
      integ_r      <= GAIN_W'(pmsd_pkg::INTEG_RESET);
      deriv_r      <= GAIN_W'(pmsd_pkg::DERIV_RESET);
      prev_error_r <= '0;
      duty_reg_r   <= DUTY_W'(pmsd_pkg::DUTY_RESET);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      target_r     <= target_nxt;
      prop_r       <= prop_nxt;
      integ_r      <= integ_nxt;
      deriv_r      <= deriv_nxt;
      prev_error_r <= prev_error_nxt;
      duty_reg_r   <= duty_reg_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    speed_r    <= speed_nxt;
    err_r      <= err_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    acc_r      <= acc_nxt;
    sg_r       <= sg_nxt;
    dv1_r      <= dv1_nxt;
    dv3_r      <= dv3_nxt;
    rem1_r     <= rem1_nxt;
    rem3_r     <= rem3_nxt;
    t2mag_r    <= t2mag_nxt;
    sum_r      <= sum_nxt;
    corr_r     <= corr_nxt;
    out_duty_r <= out_duty_nxt;
    out_corr_r <= out_corr_nxt;
    out_meas_r <= out_meas_nxt;
  end

  // Channel outputs.
  assign in_chan.ready           = (state_r == ST_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.duty           = out_duty_r;
  assign out_chan.correction     = out_corr_r;
  assign out_chan.measured_speed = out_meas_r;

  // Checks on the block's own behavior.
  `PMSD_ASSERT_IMP(a_duty_range, clk, rst_n, out_chan.valid, (out_chan.duty >= DUTY_W'(DUTY_LO)) && (out_chan.duty <= DUTY_W'(DUTY_HI)), "duty left the saturation range")
  `PMSD_ASSERT_IMP(a_corr_range, clk, rst_n, out_chan.valid, (out_chan.correction >= CORR_LO) && (out_chan.correction <= CORR_HI), "correction escaped the fold rule")
  `PMSD_ASSERT_NXT(a_one_item, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready, "second item taken while one is in flight")
  `PMSD_ASSERT_NXT(a_state_hold, clk, rst_n, state_r != ST_FIN, $stable(prev_error_r) && $stable(duty_reg_r), "controller state changed outside the commit step")

endmodule

// ===== bench/pmsd_duty_checker.sv =====
// Checker for the PID speed controller: predicts each duty update and compares it.
// Depends on pmsd_pkg and the pmsd_in_if / pmsd_out_if channel interfaces.
`timescale 1ns / 1ps

module pmsd_duty_checker
  import pmsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  pmsd_in_if                   in_mon,
  pmsd_out_if                  out_mon,
  output int unsigned          outstanding,
  output int unsigned          fail_count
);

  localparam int PULSE_W = COUNT_BITS_DEF;
  localparam int GFB     = GAIN_FRAC_BITS_DEF;

  // Divisors of the three Q.16 terms and of the final correction.
  localparam longint PROP_DIV  = longint'(T1_DIV) << (GFB + 4);
  localparam longint DERIV_DIV = longint'(1) << (GFB - 3);
  localparam longint INTEG_DIV = longint'(T3_DIV) << (GFB - 4);
  localparam longint Q16_ONE   = longint'(1) << TERM_SHIFT;

  typedef struct {
    logic [DUTY_W-1:0]        duty;
    logic signed [CORR_W-1:0] correction;
    logic [MEAS_W-1:0]        measured_speed;
  } duty_update_t;

  // Register copies and controller state.
  logic [CFG_W-1:0]         target_rpm;
  logic signed [GAIN_W-1:0] kp_q88;
  logic signed [GAIN_W-1:0] ki_q88;
  logic signed [GAIN_W-1:0] kd_q88;
  longint                   last_error;
  logic [DUTY_W-1:0]        duty_now;

  duty_update_t expected_updates[$];
  int unsigned  mismatches = 0;
  int unsigned  pending_cnt = 0;
  int unsigned  update_idx = 0;

  assign outstanding = pending_cnt;
  assign fail_count  = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] duty update %0d: %s", $time, update_idx, msg);
    mismatches++;
  endtask

  // One sampling tick: speed, error, PID terms, fold rule, duty saturation.
  function automatic duty_update_t predict_duty_update(input logic [PULSE_W-1:0] pulses);
    duty_update_t res;
    longint rpm;
    longint err;
    longint kp;
    longint ki;
    longint kd;
    longint p_term;
    longint i_term;
    longint d_term;
    longint corr;
    longint next_duty;
    rpm = pulses;
    rpm = (rpm * SPEED_MUL) >> SPEED_SHIFT;
    err = target_rpm;
    err = err - rpm;
    kp = kp_q88;
    ki = ki_q88;
    kd = kd_q88;
    p_term = (kp * err * Q16_ONE) / PROP_DIV;
    d_term = (kd * (err - last_error) * T2_MUL) / DERIV_DIV;
    i_term = (ki * (err + last_error) * Q16_ONE) / INTEG_DIV;
    corr = (p_term + d_term + i_term) / Q16_ONE;

    // Large corrections fold back to a fixed step.
    if (corr >= FOLD_LIMIT) corr = FOLD_VALUE;
    else if (corr <= -FOLD_LIMIT) corr = -FOLD_VALUE;

    next_duty = duty_now;
    next_duty = next_duty - corr;
    if (next_duty > DUTY_MAX) next_duty = DUTY_MAX;
    else if (next_duty < DUTY_MIN) next_duty = DUTY_MIN;

    duty_now = next_duty[DUTY_W-1:0];
    last_error = err;
    res.duty = duty_now;
    res.correction = corr[CORR_W-1:0];
    res.measured_speed = rpm[MEAS_W-1:0];
    return res;
  endfunction

  // Results are checked before new items are predicted at the same edge.
  always @(posedge clk) begin : watch
    duty_update_t want;
    if (!rst_n) begin
      target_rpm <= TARGET_RESET;
      kp_q88 <= PROP_RESET;
      ki_q88 <= INTEG_RESET;
      kd_q88 <= DERIV_RESET;
      last_error = 0;
      duty_now = DUTY_RESET;
      expected_updates.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_updates.size() == 0) begin
          report_mismatch("result arrived with no item outstanding");
        end else begin
          want = expected_updates.pop_front();
          if (out_mon.duty !== want.duty)
            report_mismatch($sformatf("duty got %0d expected %0d", out_mon.duty, want.duty));
          if (out_mon.correction !== want.correction)
            report_mismatch($sformatf("correction got %0d expected %0d",
                                      out_mon.correction, want.correction));
          if (out_mon.measured_speed !== want.measured_speed)
            report_mismatch($sformatf("measured_speed got %0d expected %0d",
                                      out_mon.measured_speed, want.measured_speed));
        end
        update_idx++;
      end
      if (in_mon.valid && in_mon.ready)
        expected_updates.push_back(predict_duty_update(in_mon.pulse_count));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TARGET_SPEED: target_rpm <= cfg_data;
          CFG_PROP_GAIN:    kp_q88 <= cfg_data;
          CFG_INTEG_GAIN:   ki_q88 <= cfg_data;
          CFG_DERIV_GAIN:   kd_q88 <= cfg_data;
          default: ;
        endcase
      end
    end
    pending_cnt <= expected_updates.size();
  end

endmodule

// ===== bench/pid_motor_speed_duty_update_tb.sv =====
// Top of the PID speed controller bench: clock, reset, stimulus and the verdict.
// Depends on pmsd_pkg, the channel interfaces, the RTL top and pmsd_duty_checker.
`timescale 1ns / 1ps

module pid_motor_speed_duty_update_tb;
  import pmsd_pkg::*;

  localparam int          PULSE_W      = COUNT_BITS_DEF;
  localparam int          RANDOM_ITEMS = 1200;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          SETTLE       = 100;
  localparam int unsigned CYCLE_LIMIT  = 1500000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          outstanding;
  int unsigned          fail_count;
  int unsigned          cycle_cnt = 0;

  // Flags handed from the stimulus to the result sink.
  bit          calm = 1'b0;
  int unsigned hold_asks = 0;

  pmsd_in_if #(.COUNT_BITS(PULSE_W)) in_chan ();
  pmsd_out_if                        out_chan ();

  pid_motor_speed_duty_update DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  pmsd_duty_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("pid_motor_speed_duty_update verification failed");
      $finish;
    end
  end

  // Result sink: random stalls, occasional long ones, and requested hold-offs.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_grants;
    stall_left = 0;
    hold_grants = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_grants != hold_asks) begin
        hold_grants++;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (stall_left != 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 14) begin
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(1, 150) : 0;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] kp,
                            input logic [CFG_W-1:0] ki, input logic [CFG_W-1:0] kd);
    write_reg(CFG_TARGET_SPEED, tgt);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    cfg_we <= 1'b0;
  endtask

  // Offer one pulse count and return at the edge where it is taken.
  task automatic send_pulses(input logic [PULSE_W-1:0] pulses);
    in_chan.valid <= 1'b1;
    in_chan.pulse_count <= pulses;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Random sender gap after an item, of random length.
  task automatic pace();
    if (!calm && $urandom_range(99) < 14) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 2048) - 1024);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(500, 12000));
    endcase
  endfunction

  // Mostly counts close to the target speed, so the loop regulates; the rest anywhere.
  function automatic logic [PULSE_W-1:0] pick_pulses(input int unsigned tgt);
    int centre;
    int cnt;
    if ($urandom_range(99) < 65) begin
      centre = int'((tgt << SPEED_SHIFT) / SPEED_MUL);
      cnt = centre + int'($urandom_range(0, 8)) - 4;
      if (cnt < 0) cnt = 0;
      return cnt[PULSE_W-1:0];
    end
    return PULSE_W'($urandom_range(0, (1 << PULSE_W) - 1));
  endfunction

  initial begin : stimulus
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      phase_len;
    logic [CFG_W-1:0] tgt;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TARGET_SPEED;
    cfg_data <= '0;
    in_chan.valid <= 1'b0;
    in_chan.pulse_count <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero count, full-scale count, a single pulse.
    send_pulses(0);
    pace();
    send_pulses(1023);
    pace();
    send_pulses(1);
    pace();

    // Correction of exactly 19 each tick drives the duty down to its floor.
    wait_all_results();
    set_config(16'hFFFF, 16'd743, 16'd0, 16'd0);
    repeat (7) begin
      send_pulses(0);
      pace();
    end

    // Correction of -19 each tick drives the duty up to its ceiling.
    wait_all_results();
    set_config(16'hFFFF, -16'sd743, 16'd0, 16'd0);
    repeat (14) begin
      send_pulses(0);
      pace();
    end

    // Extreme gains of every kind: large corrections fold in both directions.
    wait_all_results();
    set_config(16'd0, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_pulses(1023);
    pace();
    send_pulses(0);
    pace();
    send_pulses(1023);
    pace();

    // Random phases, each with its own settings.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_all_results();
      if (phase == 1) tgt = 16'hFFFF;
      else if (phase == 5) tgt = 16'd0;
      else tgt = pick_target();
      if (phase == 1) set_config(tgt, 16'h8000, 16'h8000, 16'h7FFF);
      else if (phase == 5) set_config(tgt, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      else set_config(tgt, pick_gain(), pick_gain(), pick_gain());
      calm <= (phase == 2);
      phase_len = (phase == 2) ? 150 : $urandom_range(30, 110);
      for (int k = 0; k < phase_len; k++) begin
        if ((phase == 3 || phase == 8) && k == 10) hold_asks <= hold_asks + 1;
        if (phase == 4 && k == 15) wait_all_results();
        send_pulses(pick_pulses(tgt));
        pace();
        sent++;
      end
      phase++;
    end

    // Drain, then watch a while longer for stray results.
    wait_all_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("pid_motor_speed_duty_update verification clean");
    end else begin
      $display("pid_motor_speed_duty_update verification failed");
    end
    $finish;
  end

endmodule
